### rtl/mbss_pkg.sv
// ============================================================================
// mbss_pkg
// Shared types, constants and the per-byte compare rule of the masked byte
// signature scanner.
// ============================================================================
package mbss_pkg;

   // Signature and stream geometry
   localparam int MAX_SIGNATURE_DEFAULT = 16;
   localparam int SIG_BYTES             = 16;
   localparam int ADDR_W                = 48;
   localparam int LEN_W                 = 5;
   localparam int CSR_DATA_W            = 64;
   localparam int CSR_INDEX_W           = 2;
   localparam int MODES_W               = 2 * SIG_BYTES;

   localparam logic [7:0] HI_NIBBLE_MASK = 8'hF0;
   localparam logic [7:0] LO_NIBBLE_MASK = 8'h0F;

   // Register map
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PATTERN_LOW    = 2'd0,
      CSR_PATTERN_HIGH   = 2'd1,
      CSR_BYTE_MODES     = 2'd2,
      CSR_PATTERN_LENGTH = 2'd3
   } csr_index_type;

   // Per-byte compare modes
   typedef enum logic [1:0] {
      MODE_EXACT     = 2'd0,
      MODE_ANY       = 2'd1,
      MODE_NIBBLE    = 2'd2,
      MODE_EXACT_ALT = 2'd3
   } byte_mode_type;

   typedef logic [SIG_BYTES-1:0][7:0] sig_bytes_type;

   // One signature byte against one data byte
   function automatic logic byte_ok(input byte_mode_type mode, input logic [7:0] pat,
                                    input logic [7:0] data);
      logic hi_ok;
      logic lo_ok;
      logic ok;
      hi_ok = ((pat & HI_NIBBLE_MASK) == 8'h00) ||
              ((pat & HI_NIBBLE_MASK) == (data & HI_NIBBLE_MASK));
      lo_ok = ((pat & LO_NIBBLE_MASK) == 8'h00) ||
              ((pat & LO_NIBBLE_MASK) == (data & LO_NIBBLE_MASK));
      unique case (mode)
         MODE_ANY:       ok = 1'b1;
         MODE_NIBBLE:    ok = hi_ok && lo_ok;
         MODE_EXACT,
         MODE_EXACT_ALT: ok = (pat == data);
         default:        ok = (pat == data);
      endcase
      return ok;
   endfunction

endpackage

### rtl/mbss_req_if.sv
// ============================================================================
// mbss_req_if
// Input channel of the scanner: one memory byte with its address and markers.
// ============================================================================
interface mbss_req_if;
   import mbss_pkg::*;

   logic              valid;
   logic              ready;
   logic [7:0]        data_byte;
   logic [ADDR_W-1:0] byte_address;
   logic              region_start;
   logic              scan_start;
   logic              scan_end;

   modport source (output valid, data_byte, byte_address, region_start, scan_start,
                   scan_end, input ready);
   modport sink   (input valid, data_byte, byte_address, region_start, scan_start,
                   scan_end, output ready);
endinterface

### rtl/mbss_rsp_if.sv
// ============================================================================
// mbss_rsp_if
// Result channel of the scanner: found flag and match start address.
// ============================================================================
interface mbss_rsp_if;
   import mbss_pkg::*;

   logic              valid;
   logic              ready;
   logic              found;
   logic [ADDR_W-1:0] match_address;

   modport source (output valid, found, match_address, input ready);
   modport sink   (input valid, found, match_address, output ready);
endinterface

### rtl/mbss_match.sv
// ============================================================================
// mbss_match
// Parallel compare of the byte window against the masked signature. The
// signature is aligned so that its last byte sits on the newest window byte.
// ============================================================================
module mbss_match #(
   parameter int WIN_DEPTH = mbss_pkg::SIG_BYTES
) (
   input  logic [WIN_DEPTH-1:0][7:0]    window,
   input  logic [mbss_pkg::LEN_W-1:0]   fill,
   input  logic [mbss_pkg::LEN_W-1:0]   sig_len,
   input  mbss_pkg::sig_bytes_type      sig_bytes,
   input  logic [mbss_pkg::MODES_W-1:0] sig_modes,
   output logic                         hit
);
   import mbss_pkg::*;

   logic [SIG_BYTES-1:0][7:0] win_pad;
   logic [SIG_BYTES-1:0][3:0] win_sel;
   logic [SIG_BYTES-1:0]      byte_hit;

   // Zero-pad the window to the full signature width
   always_comb begin
      win_pad = '0;
      for (int i = 0; i < SIG_BYTES; i++) begin
         if (i < WIN_DEPTH) begin
            win_pad[i] = window[i];
         end
      end
   end

   // Signature byte k compares with window entry len-1-k; bytes past len pass
   always_comb begin
      for (int k = 0; k < SIG_BYTES; k++) begin
         win_sel[k]  = 4'(sig_len - 5'd1 - LEN_W'(k));
         byte_hit[k] = (LEN_W'(k) >= sig_len) ||
                       byte_ok(byte_mode_type'(sig_modes[2*k +: 2]), sig_bytes[k],
                               win_pad[win_sel[k]]);
      end
   end

   assign hit = (fill >= sig_len) && (&byte_hit);

endmodule

### rtl/masked_byte_signature_scanner.sv
// ============================================================================
// masked_byte_signature_scanner
// Streams memory bytes and reports the first match of a masked signature.
// ============================================================================
// Usage:
//   req_chan carries one byte per item with its 48-bit address and the
//   region_start / scan_start / scan_end markers. rsp_chan carries at most
//   one result per item: found with the match start address, or not-found
//   (address zero) on the last byte of a scan that had no match.
//   Registers are written through csr_wr_en / csr_index / csr_wr_data,
//   by the user only while the block is idle, which it does not enforce:
//   0 pattern low, 1 pattern high, 2 byte modes, 3 pattern length.
//   Throughput is one item per cycle unless rsp_chan stalls; the result of
//   an item is on rsp_chan in the cycle after its accept; window shift and all
//   signature compares are done in the accept cycle into the result register.
//   Reset (synchronous) opens a scan, empties the window and drops any result.
//   When rsp_chan stalls with a result held, req_chan is held off until the
//   result is taken; taking it frees the input in the same cycle.
// ============================================================================
module masked_byte_signature_scanner #(
   parameter int MAX_SIGNATURE = mbss_pkg::MAX_SIGNATURE_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   mbss_req_if.sink                        req_chan,
   mbss_rsp_if.source                      rsp_chan,
   input  logic                            csr_wr_en,
   input  logic [mbss_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [mbss_pkg::CSR_DATA_W-1:0]  csr_wr_data
);
   import mbss_pkg::*;

   localparam int WIN_DEPTH = (MAX_SIGNATURE < SIG_BYTES) ? MAX_SIGNATURE : SIG_BYTES;
   localparam int FILL_W    = $clog2(WIN_DEPTH + 1);

   // Configuration registers
   logic [63:0]      pattern_low_ff;
   logic [63:0]      pattern_high_ff;
   logic [MODES_W-1:0] byte_modes_ff;
   logic [LEN_W-1:0] pattern_length_ff;

   // Scan state
   logic [WIN_DEPTH-1:0][7:0] win_ff, win_in;
   logic [FILL_W-1:0]         fill_ff, fill_in;
   logic                      seen_ff, seen_in;

   // Result register
   logic              rsp_valid_ff;
   logic              found_ff, found_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;

   logic             accept;
   logic             win_clear;
   logic             scan_open;
   logic             hit;
   logic             emit;
   logic [LEN_W-1:0] sig_len;
   sig_bytes_type    sig_bytes;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_low_ff    <= '0;
         pattern_high_ff   <= '0;
         byte_modes_ff     <= '0;
         pattern_length_ff <= LEN_W'(1);
      end else if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_PATTERN_LOW:    pattern_low_ff    <= csr_wr_data;
            CSR_PATTERN_HIGH:   pattern_high_ff   <= csr_wr_data;
            CSR_BYTE_MODES:     byte_modes_ff     <= csr_wr_data[MODES_W-1:0];
            CSR_PATTERN_LENGTH: pattern_length_ff <= csr_wr_data[LEN_W-1:0];
            default: ;
         endcase
      end
   end

   // Effective signature length: zero acts as one, clipped to the window
   always_comb begin
      priority if (pattern_length_ff == '0) begin
         sig_len = LEN_W'(1);
      end else if (pattern_length_ff > LEN_W'(WIN_DEPTH)) begin
         sig_len = LEN_W'(WIN_DEPTH);
      end else begin
         sig_len = pattern_length_ff;
      end
   end

   assign sig_bytes = {pattern_high_ff, pattern_low_ff};

   // Handshake: a held result blocks input until it is taken
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;

   // Window shift; region or scan start empties it (fill restarts at one)
   assign win_clear = req_chan.region_start || req_chan.scan_start;

   always_comb begin
      win_in[0] = req_chan.data_byte;
      for (int i = 1; i < WIN_DEPTH; i++) begin
         win_in[i] = win_ff[i-1];
      end
   end

   always_comb begin
      priority if (win_clear) begin
         fill_in = FILL_W'(1);
      end else if (fill_ff == FILL_W'(WIN_DEPTH)) begin
         fill_in = fill_ff;
      end else begin
         fill_in = fill_ff + FILL_W'(1);
      end
   end

   mbss_match #(
      .WIN_DEPTH (WIN_DEPTH)
   ) u_match (
      .window    (win_in),
      .fill      (LEN_W'(fill_in)),
      .sig_len   (sig_len),
      .sig_bytes (sig_bytes),
      .sig_modes (byte_modes_ff),
      .hit       (hit)
   );

   // Result decision: first match or not-found at scan end, once per scan
   assign scan_open = req_chan.scan_start || !seen_ff;
   assign emit      = scan_open && (hit || req_chan.scan_end);
   assign seen_in   = !scan_open || emit;
   assign found_in  = hit;
   assign addr_in   = hit ? (req_chan.byte_address - ADDR_W'(sig_len - LEN_W'(1)))
                          : '0;

   // Scan state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         seen_ff <= 1'b0;
      end else if (accept) begin
         fill_ff <= fill_in;
         seen_ff <= seen_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         win_ff <= win_in;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept && emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && emit) begin
         found_ff <= found_in;
         addr_ff  <= addr_in;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.found         = found_ff;
   assign rsp_chan.match_address = addr_ff;

   // Checks
   a_notfound_zero_addr: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !found_ff |-> addr_ff == '0)
      else $error("not-found result carries a nonzero address");

   a_emit_closes_scan: assert property (@(posedge clock) disable iff (reset)
      accept && emit |=> seen_ff && rsp_valid_ff)
      else $error("result emitted without closing the scan");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(WIN_DEPTH))
      else $error("window fill beyond window depth");

   a_idle_state_holds: assert property (@(posedge clock) disable iff (reset)
      !accept |=> $stable(fill_ff) && $stable(seen_ff))
      else $error("scan state changed without an accepted item");

   a_closed_scan_silent: assert property (@(posedge clock) disable iff (reset)
      accept && seen_ff && !req_chan.scan_start |-> !emit)
      else $error("result from a closed scan");

endmodule
